// ===== rtl/esv_pkg.sv =====
package esv_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAG_BITS = SAMPLE_BITS + 1;

	localparam int POS_BITS = 16;
	localparam int VBITS_BITS = 5;
	localparam int PERCENT_BITS = 7;
	localparam int COUNT_BITS = 8;
	localparam int HOLD_BITS = 16;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	// Error window and alarm timing
	localparam int WINDOW_LAST = 200;
	localparam int RATE_WINDOW = 202;
	localparam int PERCENT_SCALE = 100;
	localparam int ALARM_LIMIT = 200;
	localparam int ALARM_MAX = 255;
	localparam int TABLE_DEPTH = 1 << COUNT_BITS;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_VALID_BITS    = 3'd0,
		REG_TURN_MAX      = 3'd1,
		REG_JUMP_LIMIT    = 3'd2,
		REG_ERROR_LEVEL   = 3'd3,
		REG_HOLDOFF_TICKS = 3'd4
	} esv_reg_t;

	localparam logic [VBITS_BITS-1:0] VALID_BITS_RST = 5'd16;
	localparam logic [POS_BITS-1:0] TURN_MAX_RST = 16'd4095;
	localparam logic [POS_BITS-1:0] JUMP_LIMIT_RST = 16'd100;
	localparam logic [PERCENT_BITS-1:0] ERROR_LEVEL_RST = 7'd10;
	localparam logic [HOLD_BITS-1:0] HOLDOFF_TICKS_RST = 16'd100;

	typedef logic [PERCENT_BITS-1:0] percent_t;

	typedef struct packed {
		logic [VBITS_BITS-1:0] valid_bits;
		logic [POS_BITS-1:0] turn_max;
		logic [POS_BITS-1:0] jump_limit;
		percent_t error_level;
		logic [HOLD_BITS-1:0] holdoff_ticks;
	} esv_cfg_t;

	typedef struct packed {
		logic [POS_BITS-1:0] position;
		logic sample_good;
		percent_t error_percent;
		logic alarm;
	} esv_result_t;

	typedef percent_t rate_table_t [TABLE_DEPTH];

	// Error count of one window to truncated percentage of the window length
	function automatic rate_table_t build_rate_table();
		rate_table_t t;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			t[i] = percent_t'((i * PERCENT_SCALE) / RATE_WINDOW);
		end
		return t;
	endfunction

	localparam rate_table_t RATE_TABLE = build_rate_table();

endpackage

// ===== rtl/esv_sample_if.sv =====
interface esv_sample_if
	import esv_pkg::*;
();
	logic valid;
	logic ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/esv_result_if.sv =====
interface esv_result_if
	import esv_pkg::*;
();
	logic valid;
	logic ready;
	logic [POS_BITS-1:0] position;
	logic sample_good;
	logic [PERCENT_BITS-1:0] error_percent;
	logic alarm;

	modport source (output valid, output position, output sample_good,
		output error_percent, output alarm, input ready);
	modport sink (input valid, input position, input sample_good,
		input error_percent, input alarm, output ready);
endinterface

// ===== rtl/esv_cfg_if.sv =====
interface esv_cfg_if
	import esv_pkg::*;
();
	logic valid;
	logic ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/encoder_sample_validator_unit.sv =====
// Encoder sample validator.
// Channels: samples carries one raw encoder word per transfer; results
// returns one item per sample with the held position, the good flag of
// that sample, the error percentage of the last completed 202-sample
// window and the sticky alarm. cfg writes the five setup registers by
// index (valid_bits, turn_max, jump_limit, error_level, holdoff_ticks);
// it is always ready and should be written only while no sample is in
// flight.
// Path: a sample taken on samples waits in the input stage register, then
// moves into the result register, which drives results. Throughput: one
// sample per cycle while results is not stalled; the check and all state
// updates sit between the input stage register and the result register.
// Reset: arst_n clears the history, counters, alarm and the pipeline and
// loads the register defaults (16, 4095, 100, 10, 100).
// Stall: while results is stalled the result register holds its item,
// the input stage keeps one more sample, and samples.ready then drops
// until the result is taken.
module encoder_sample_validator_unit
	import esv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	esv_sample_if.sink samples,
	esv_result_if.source results,
	esv_cfg_if.sink cfg
);

	esv_cfg_t regs;
	logic valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic out_valid_q;
	esv_result_t result_q;
	esv_result_t result_next;
	logic [SAMPLE_BITS-1:0] prev_sample;
	logic good;
	logic advance;

	esv_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.regs(regs)
	);

	esv_check u_check (
		.sample(sample_s1),
		.prev_sample(prev_sample),
		.regs(regs),
		.good(good)
	);

	esv_track u_track (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.sample(sample_s1),
		.good(good),
		.regs(regs),
		.prev_sample(prev_sample),
		.result_next(result_next)
	);

	assign advance = valid_s1 && (!out_valid_q || results.ready);
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (samples.ready) valid_s1 <= samples.valid;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) sample_s1 <= samples.sample;
		if (advance) result_q <= result_next;
	end

	assign results.valid = out_valid_q;
	assign results.position = result_q.position;
	assign results.sample_good = result_q.sample_good;
	assign results.error_percent = result_q.error_percent;
	assign results.alarm = result_q.alarm;

endmodule

// ===== rtl/esv_cfg_regs.sv =====
module esv_cfg_regs
	import esv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	esv_cfg_if.sink cfg,
	output esv_cfg_t regs
);

	esv_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.valid_bits <= VALID_BITS_RST;
			regs_q.turn_max <= TURN_MAX_RST;
			regs_q.jump_limit <= JUMP_LIMIT_RST;
			regs_q.error_level <= ERROR_LEVEL_RST;
			regs_q.holdoff_ticks <= HOLDOFF_TICKS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_VALID_BITS: regs_q.valid_bits <= cfg.data[VBITS_BITS-1:0];
				REG_TURN_MAX: regs_q.turn_max <= cfg.data[POS_BITS-1:0];
				REG_JUMP_LIMIT: regs_q.jump_limit <= cfg.data[POS_BITS-1:0];
				REG_ERROR_LEVEL: regs_q.error_level <= cfg.data[PERCENT_BITS-1:0];
				REG_HOLDOFF_TICKS: regs_q.holdoff_ticks <= cfg.data[HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/esv_check.sv =====
module esv_check
	import esv_pkg::*;
(
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [SAMPLE_BITS-1:0] prev_sample,
	input  esv_cfg_t regs,
	output logic good
);

	logic [SAMPLE_BITS-1:0] diff;
	logic [MAG_BITS-1:0] mag;
	logic [MAG_BITS-1:0] full_turn;
	logic [POS_BITS-1:0] low_edge;
	logic out_of_range;
	logic small_jump;
	logic wrap_jump;

	assign full_turn = MAG_BITS'(1) << SAMPLE_BITS;
	assign diff = sample - prev_sample;

	// Wrapped difference read as signed, then its magnitude
	assign mag = diff[SAMPLE_BITS-1] ? (full_turn - {1'b0, diff}) : {1'b0, diff};

	assign out_of_range = (32'(regs.valid_bits) < SAMPLE_BITS) &&
		((sample >> regs.valid_bits) != '0);

	// Lower edge of the wrap window holds at zero when the limit passes turn_max
	assign low_edge = (regs.turn_max >= regs.jump_limit) ?
		(regs.turn_max - regs.jump_limit) : '0;

	assign small_jump = mag < MAG_BITS'(regs.jump_limit);
	assign wrap_jump = (mag >= MAG_BITS'(low_edge)) && (mag <= MAG_BITS'(regs.turn_max));

	assign good = !out_of_range && (small_jump || wrap_jump);

endmodule

// ===== rtl/esv_track.sv =====
module esv_track
	import esv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic good,
	input  esv_cfg_t regs,
	output logic [SAMPLE_BITS-1:0] prev_sample,
	output esv_result_t result_next
);

	logic [SAMPLE_BITS-1:0] prev_q;
	logic [POS_BITS-1:0] held_q;
	logic hold_active_q;
	logic [HOLD_BITS-1:0] hold_count_q;
	logic [COUNT_BITS-1:0] win_errors_q;
	logic [COUNT_BITS-1:0] win_samples_q;
	percent_t rate_q;
	logic [COUNT_BITS-1:0] alarm_count_q;
	logic alarm_q;

	logic [POS_BITS-1:0] held_d;
	logic hold_mid;
	logic hold_active_d;
	logic [HOLD_BITS:0] hold_inc;
	logic [HOLD_BITS-1:0] hold_count_d;
	logic [COUNT_BITS-1:0] err_mid;
	logic [COUNT_BITS-1:0] win_errors_d;
	logic [COUNT_BITS-1:0] win_samples_d;
	percent_t rate_d;
	logic [COUNT_BITS-1:0] alarm_count_d;
	logic alarm_d;

	assign prev_sample = prev_q;

	always_comb begin
		// Bad sample starts holdoff before the position update is decided
		hold_mid = hold_active_q || !good;
		held_d = (good && !hold_active_q) ? (POS_BITS'(sample) & regs.turn_max) : held_q;

		hold_inc = {1'b0, hold_count_q} + 1'b1;
		hold_active_d = hold_mid;
		hold_count_d = hold_count_q;
		if (hold_mid) begin
			if (hold_inc > {1'b0, regs.holdoff_ticks}) begin
				hold_count_d = '0;
				hold_active_d = 1'b0;
			end else begin
				hold_count_d = hold_inc[HOLD_BITS-1:0];
			end
		end

		err_mid = win_errors_q + COUNT_BITS'(!good);
		if (win_samples_q > COUNT_BITS'(WINDOW_LAST)) begin
			rate_d = RATE_TABLE[err_mid];
			win_errors_d = '0;
			win_samples_d = '0;
		end else begin
			rate_d = rate_q;
			win_errors_d = err_mid;
			win_samples_d = win_samples_q + 1'b1;
		end

		alarm_d = alarm_q;
		if (rate_d > regs.error_level) begin
			if (alarm_count_q > COUNT_BITS'(ALARM_LIMIT)) alarm_d = 1'b1;
			alarm_count_d = (alarm_count_q < COUNT_BITS'(ALARM_MAX)) ?
				alarm_count_q + 1'b1 : alarm_count_q;
		end else begin
			alarm_count_d = '0;
		end

		result_next.position = held_d;
		result_next.sample_good = good;
		result_next.error_percent = rate_d;
		result_next.alarm = alarm_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			held_q <= '0;
			hold_active_q <= 1'b0;
			hold_count_q <= '0;
			win_errors_q <= '0;
			win_samples_q <= '0;
			rate_q <= '0;
			alarm_count_q <= '0;
			alarm_q <= 1'b0;
		end else if (advance) begin
			prev_q <= sample;
			held_q <= held_d;
			hold_active_q <= hold_active_d;
			hold_count_q <= hold_count_d;
			win_errors_q <= win_errors_d;
			win_samples_q <= win_samples_d;
			rate_q <= rate_d;
			alarm_count_q <= alarm_count_d;
			alarm_q <= alarm_d;
		end
	end

endmodule

// ===== rtl/esv_checker.sv =====
module esv_checker
	import esv_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [POS_BITS-1:0] position,
	input logic sample_good,
	input logic [PERCENT_BITS-1:0] error_percent,
	input logic alarm
);

	logic xfer;
	logic alarm_seen_q;
	logic [POS_BITS-1:0] last_pos_q;

	assign xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_seen_q <= 1'b0;
			last_pos_q <= '0;
		end else if (xfer) begin
			if (alarm) alarm_seen_q <= 1'b1;
			last_pos_q <= position;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) &&
			$stable(sample_good) && $stable(error_percent) && $stable(alarm))
		else $error("result changed while stalled");

	a_alarm_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && alarm_seen_q |-> alarm)
		else $error("alarm dropped after being raised");

	a_percent_range: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> error_percent <= PERCENT_BITS'(PERCENT_SCALE))
		else $error("error percentage above 100");

	a_bad_holds_pos: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !sample_good |-> position == last_pos_q)
		else $error("position moved on a bad sample");

endmodule

bind encoder_sample_validator_unit esv_checker u_esv_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.position(results.position),
	.sample_good(results.sample_good),
	.error_percent(results.error_percent),
	.alarm(results.alarm)
);

// ===== test/tb_encoder_sample_validator_unit.sv =====
module tb_encoder_sample_validator_unit;
	import esv_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_TICKS = 8;
	localparam int PRINT_CAP = 40;

	// Tracks the expected result of every sample taken by the block.
	class encoder_scoreboard;
		esv_cfg_t regs;
		logic [SAMPLE_BITS-1:0] prev_word;
		logic [POS_BITS-1:0] held_pos;
		bit hold_on;
		logic [HOLD_BITS-1:0] hold_count;
		logic [COUNT_BITS-1:0] win_errors;
		logic [COUNT_BITS-1:0] win_samples;
		percent_t rate;
		logic [COUNT_BITS-1:0] alarm_timer;
		bit alarm_latched;
		esv_result_t expected_q[$];
		int mismatches;
		int checked;
		int good_seen;
		int bad_seen;
		int alarm_seen;

		function new();
			regs.valid_bits = VALID_BITS_RST;
			regs.turn_max = TURN_MAX_RST;
			regs.jump_limit = JUMP_LIMIT_RST;
			regs.error_level = ERROR_LEVEL_RST;
			regs.holdoff_ticks = HOLDOFF_TICKS_RST;
			prev_word = '0;
			held_pos = '0;
			hold_on = 1'b0;
			hold_count = '0;
			win_errors = '0;
			win_samples = '0;
			rate = '0;
			alarm_timer = '0;
			alarm_latched = 1'b0;
			mismatches = 0;
			checked = 0;
			good_seen = 0;
			bad_seen = 0;
			alarm_seen = 0;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("mismatch at %0t: %s", $realtime, msg);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(esv_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
			case (idx)
				REG_VALID_BITS: regs.valid_bits = value[VBITS_BITS-1:0];
				REG_TURN_MAX: regs.turn_max = value[POS_BITS-1:0];
				REG_JUMP_LIMIT: regs.jump_limit = value[POS_BITS-1:0];
				REG_ERROR_LEVEL: regs.error_level = value[PERCENT_BITS-1:0];
				REG_HOLDOFF_TICKS: regs.holdoff_ticks = value[HOLD_BITS-1:0];
				default: ;
			endcase
		endfunction

		// Advance the validator state by one sample and queue its result.
		function void note_sample(logic [SAMPLE_BITS-1:0] s);
			logic [SAMPLE_BITS-1:0] diff;
			int unsigned mag;
			int unsigned tm;
			int unsigned jl;
			int unsigned low_edge;
			int unsigned nxt;
			int unsigned r;
			bit out_of_range;
			bit good;
			esv_result_t exp_item;
			tm = regs.turn_max;
			jl = regs.jump_limit;
			diff = s - prev_word;
			mag = diff;
			if (mag >= (1 << (SAMPLE_BITS - 1)))
				mag = (1 << SAMPLE_BITS) - mag;
			out_of_range = 1'b0;
			if (regs.valid_bits < SAMPLE_BITS)
				out_of_range = (s >> regs.valid_bits) != 0;
			low_edge = (tm >= jl) ? tm - jl : 0;
			good = !out_of_range && (mag < jl || (mag >= low_edge && mag <= tm));
			if (!good) begin
				win_errors = win_errors + 1'b1;
				hold_on = 1'b1;
			end
			if (good && !hold_on)
				held_pos = s & regs.turn_max;
			prev_word = s;
			if (hold_on) begin
				// compare one bit wider than the count
				nxt = int'(hold_count) + 1;
				if (nxt > regs.holdoff_ticks) begin
					hold_count = '0;
					hold_on = 1'b0;
				end else begin
					hold_count = nxt[HOLD_BITS-1:0];
				end
			end
			if (win_samples > WINDOW_LAST) begin
				r = (int'(win_errors) * PERCENT_SCALE) / RATE_WINDOW;
				rate = (r > 127) ? 7'd127 : r[PERCENT_BITS-1:0];
				win_errors = '0;
				win_samples = '0;
			end else begin
				win_samples = win_samples + 1'b1;
			end
			if (rate > regs.error_level) begin
				if (alarm_timer > ALARM_LIMIT)
					alarm_latched = 1'b1;
				if (alarm_timer < ALARM_MAX)
					alarm_timer = alarm_timer + 1'b1;
			end else begin
				alarm_timer = '0;
			end
			exp_item.position = held_pos;
			exp_item.sample_good = good;
			exp_item.error_percent = rate;
			exp_item.alarm = alarm_latched;
			expected_q.push_back(exp_item);
		endfunction

		function void check_result(esv_result_t got);
			esv_result_t exp_item;
			if (expected_q.size() == 0) begin
				report("result with no sample waiting for it");
				return;
			end
			exp_item = expected_q.pop_front();
			checked++;
			if (got.sample_good)
				good_seen++;
			else
				bad_seen++;
			if (got.alarm)
				alarm_seen++;
			if (got.position !== exp_item.position)
				report($sformatf("result %0d position %h, want %h", checked,
					got.position, exp_item.position));
			if (got.sample_good !== exp_item.sample_good)
				report($sformatf("result %0d sample_good %b, want %b", checked,
					got.sample_good, exp_item.sample_good));
			if (got.error_percent !== exp_item.error_percent)
				report($sformatf("result %0d error_percent %0d, want %0d", checked,
					got.error_percent, exp_item.error_percent));
			if (got.alarm !== exp_item.alarm)
				report($sformatf("result %0d alarm %b, want %b", checked,
					got.alarm, exp_item.alarm));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_count;
	bit stall_on;
	int settings_run;
	logic [SAMPLE_BITS-1:0] last_word;
	encoder_scoreboard sb;

	esv_sample_if samples_if();
	esv_result_if results_if();
	esv_cfg_if cfg_if();

	encoder_sample_validator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg(cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL encoder_sample_validator_unit");
			$finish;
		end
	end

	always @(posedge clk) begin
		esv_result_t got;
		if (arst_n && results_if.valid && results_if.ready) begin
			got.position = results_if.position;
			got.sample_good = results_if.sample_good;
			got.error_percent = results_if.error_percent;
			got.alarm = results_if.alarm;
			sb.check_result(got);
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side back-pressure.
	initial begin
		int burst;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			results_if.ready <= 1'b1;
			if (!stall_on) begin
				@(posedge clk);
			end else begin
				burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 20);
				repeat (burst) @(posedge clk);
				results_if.ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
		end
	end

	task automatic send_sample(logic [SAMPLE_BITS-1:0] s, int gap);
		samples_if.valid <= 1'b1;
		samples_if.sample <= s;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		sb.note_sample(s);
		last_word = s;
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic stop_samples();
		samples_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(esv_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		sb.write_reg(idx, value);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);
	endtask

	// Change settings only with the pipeline empty.
	task automatic apply_setting(int vb, int tm, int jl, int el, int ho);
		wait_drained();
		write_reg(REG_VALID_BITS, CFG_DATA_BITS'(vb));
		write_reg(REG_TURN_MAX, CFG_DATA_BITS'(tm));
		write_reg(REG_JUMP_LIMIT, CFG_DATA_BITS'(jl));
		write_reg(REG_ERROR_LEVEL, CFG_DATA_BITS'(el));
		write_reg(REG_HOLDOFF_TICKS, CFG_DATA_BITS'(ho));
		settings_run++;
	endtask

	// Mostly plausible motion near the last word, plus wraps, range faults and noise.
	function automatic logic [SAMPLE_BITS-1:0] make_sample();
		int unsigned vb;
		int unsigned tm;
		int unsigned jl;
		int unsigned span;
		int unsigned r;
		int off;
		int v;
		logic [SAMPLE_BITS-1:0] in_mask;
		vb = sb.regs.valid_bits;
		tm = sb.regs.turn_max;
		jl = sb.regs.jump_limit;
		in_mask = (vb >= SAMPLE_BITS) ? '1 : SAMPLE_BITS'((32'd1 << vb) - 1);
		r = $urandom_range(0, 99);
		if (r < 65) begin
			span = (jl < 300) ? jl + 2 : 300;
			off = int'($urandom_range(0, 2 * span)) - int'(span);
			v = int'(last_word) + off;
			return SAMPLE_BITS'(v) & in_mask;
		end
		if (r < 77) begin
			span = (jl < 300) ? jl : 300;
			off = int'(tm) - int'($urandom_range(0, span + 4)) + 2;
			v = $urandom_range(0, 1) ? int'(last_word) + off : int'(last_word) - off;
			return SAMPLE_BITS'(v) & in_mask;
		end
		if (r < 88 && vb < SAMPLE_BITS) begin
			v = $urandom;
			return (SAMPLE_BITS'(v) & in_mask)
				| (SAMPLE_BITS'(1) << $urandom_range(vb, SAMPLE_BITS - 1));
		end
		return SAMPLE_BITS'($urandom);
	endfunction

	task automatic run_random(int count);
		bit busy;
		int gap;
		busy = 1'b0;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 19) == 0)
				busy = ~busy;
			gap = (busy || $urandom_range(0, 1)) ? 0 : pick_gap();
			send_sample(make_sample(), gap);
		end
		stop_samples();
	endtask

	task automatic run_directed();
		// default setup: small step, step equal to the limit, wrap window, sign edge
		send_sample(16'h0000, 0);
		send_sample(16'd99, 1);
		send_sample(16'd199, 0);
		send_sample(16'd4199, 2);
		send_sample(16'hFFFF, 0);
		send_sample(16'h0000, 0);
		send_sample(16'h8000, 3);
		send_sample(16'h7FFF, 0);
		stop_samples();
		// no valid bits: any nonzero word is bad
		apply_setting(0, 4095, 100, 10, 100);
		send_sample(16'h0000, 0);
		send_sample(16'h0001, 0);
		send_sample(16'h0000, 0);
		stop_samples();
		apply_setting(8, 4095, 100, 10, 100);
		send_sample(16'h00FF, 0);
		send_sample(16'h0100, 0);
		stop_samples();
		// width beyond the word: nothing out of range
		apply_setting(31, 4095, 100, 10, 100);
		send_sample(16'hFFFF, 0);
		stop_samples();
		// limit above turn max: wrap window opens down to zero
		apply_setting(16, 0, 65535, 127, 100);
		send_sample(16'h1234, 0);
		send_sample(16'hFFFF, 0);
		stop_samples();
		apply_setting(16, 65535, 0, 0, 0);
		send_sample(16'd5, 0);
		send_sample(16'd5, 0);
		send_sample(16'd6, 0);
		stop_samples();
		apply_setting(4, 15, 3, 100, 0);
		send_sample(16'h0010, 0);
		send_sample(16'h000F, 0);
		stop_samples();
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		stall_on = 1'b1;
		settings_run = 0;
		last_word = '0;
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.sample = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_VALID_BITS;
		cfg_if.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		sb.prev_word = sb.prev_word;

		apply_setting(16, 4095, 100, 10, 100);
		run_random(60);
		apply_setting(1, 1, 0, 127, 65535);
		run_random(40);
		apply_setting(16, 65535, 65535, 100, 3);
		run_random(50);
		apply_setting(10, 1023, 2000, 50, 20);
		run_random(60);
		// sustained error rate: alarm timer runs, latches and saturates
		apply_setting(14, 16383, 300, 0, 0);
		run_random(450);
		apply_setting(0, 0, 0, 5, 7);
		run_random(40);

		// longest holdoff: one bad word, then clean words with no idling that stay held
		apply_setting(4, 65535, 65535, 100, 65535);
		stall_on = 1'b0;
		send_sample(16'h0010, 0);
		for (int i = 0; i < 80; i++)
			send_sample(SAMPLE_BITS'($urandom_range(0, 15)), 0);
		stop_samples();
		stall_on = 1'b1;

		apply_setting(16, 4095, 100, 10, 100);
		run_random(50);

		wait_drained();
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("checked %0d results over %0d register settings", sb.checked, settings_run);
		$display("good %0d, bad %0d, results with alarm set %0d",
			sb.good_seen, sb.bad_seen, sb.alarm_seen);
		if (sb.mismatches == 0) begin
			$display("PASS encoder_sample_validator_unit");
		end else begin
			$display("FAIL encoder_sample_validator_unit");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/esv_pkg.sv
rtl/esv_sample_if.sv
rtl/esv_result_if.sv
rtl/esv_cfg_if.sv
rtl/esv_cfg_regs.sv
rtl/esv_check.sv
rtl/esv_track.sv
rtl/encoder_sample_validator_unit.sv
rtl/esv_checker.sv
test/tb_encoder_sample_validator_unit.sv
